>>> hw/rtl/mmta_pkg.sv
// ----------------------------------------------------------------------------
// mmta_pkg
// Shared types and constants for the transposed matrix multiply-accumulate core.
// ----------------------------------------------------------------------------
package mmta_pkg;
    localparam int MAX_ORDER_DEF     = 8;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int ACC_W             = 40;
    localparam int ORDER_W           = 4;
    localparam int IDX_W             = 3;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_LOAD_C = 2'd2;
    localparam logic [1:0] ACT_RUN    = 2'd3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;
endpackage

>>> hw/rtl/mmta_cell.sv
// ----------------------------------------------------------------------------
// mmta_cell
// One MAC cell of the chain: takes a running sum from its left neighbor,
// adds one A*B product with saturation when active and passes it right.
// ----------------------------------------------------------------------------
module mmta_cell
    import mmta_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_active,
    input  logic signed [OPERAND_WIDTH-1:0] i_a,
    input  logic signed [OPERAND_WIDTH-1:0] i_b,
    input  logic signed [ACC_W-1:0]         i_acc,
    input  logic                            i_ovf,
    output logic                            o_valid,
    output logic signed [ACC_W-1:0]         o_acc,
    output logic                            o_ovf
);
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int SW = (PW > ACC_W ? PW : ACC_W) + 2;

    logic signed [PW-1:0]    w_prod;
    logic signed [SW-1:0]    w_sum;
    logic signed [ACC_W-1:0] n_acc;
    logic                    n_ovf;
    logic                    r_valid;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_ovf;

    always_comb begin
        w_prod = i_a * i_b;
        w_sum  = SW'(i_acc) + SW'(w_prod);
        n_acc  = i_acc;
        n_ovf  = i_ovf;
        if (i_active) begin
            if (w_sum > SW'(ACC_MAX)) begin
                n_acc = ACC_MAX;
                n_ovf = 1'b1;
            end else if (w_sum < SW'(ACC_MIN)) begin
                n_acc = ACC_MIN;
                n_ovf = 1'b1;
            end else begin
                n_acc = w_sum[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_acc <= n_acc;
        r_ovf <= n_ovf;
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_ovf   = r_ovf;
endmodule

>>> hw/rtl/matrix_multiply_transposed_accumulate_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_accumulate_core
// C = C + A * B^T on signed fixed point, with a chain of MAC cells.
// Loads: one word per cycle, busy stays low. Compute: busy until all n*n
// C elements are written back; per C element, ST_RUN fetches the A/B rows
// and C, then one pass through the MAX_ORDER-cell chain. First word appears
// after the row fetch, the feed register and the chain registers; results cannot stall.
// Reset (synchronous, active low) clears control and positions, order = MAX_ORDER.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed_accumulate_core
    import mmta_pkg::*;
#(
    parameter int MAX_ORDER     = MAX_ORDER_DEF,
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [ORDER_W-1:0]              i_cfg_data,
    input  logic [1:0]                      i_action,
    input  logic signed [OPERAND_WIDTH-1:0] i_operand_value,
    input  logic signed [ACC_W-1:0]         i_accumulator_in,
    output logic                            o_strobe,
    output logic signed [ACC_W-1:0]         o_result_value,
    output logic [IDX_W-1:0]                o_result_row,
    output logic [IDX_W-1:0]                o_result_col,
    output logic                            o_overflow,
    output logic                            o_last
);
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    t_state r_state;

    logic [ORDER_W-1:0] r_order;
    logic [KW:0]        w_n;
    logic [AW:0]        w_nn;

    logic signed [OPERAND_WIDTH-1:0] r_a_mem [DEPTH];
    logic signed [OPERAND_WIDTH-1:0] r_b_mem [DEPTH];
    logic signed [ACC_W-1:0]         r_c_mem [DEPTH];
    logic [AW:0] r_apos, r_bpos, r_cpos;

    logic [KW:0] r_i, r_j, r_k;
    logic        w_accept;

    // row registers: A row i, B row j, read one element per cycle
    logic signed [OPERAND_WIDTH-1:0] r_arow [MAX_ORDER];
    logic signed [OPERAND_WIDTH-1:0] r_brow [MAX_ORDER];
    logic signed [ACC_W-1:0]         r_c0;
    logic                            r_feed;
    logic                            r_inflight;

    logic signed [OPERAND_WIDTH-1:0] r_skew_a [MAX_ORDER][MAX_ORDER];
    logic signed [OPERAND_WIDTH-1:0] r_skew_b [MAX_ORDER][MAX_ORDER];

    logic                    w_cv  [MAX_ORDER+1];
    logic signed [ACC_W-1:0] w_cac [MAX_ORDER+1];
    logic                    w_cov [MAX_ORDER+1];

    logic [AW:0] r_emitted;

    logic          o_strobe_int;
    logic [AW-1:0] w_wb_addr;
    logic [AW-1:0] w_rd_a, w_rd_b, w_rd_c;

    assign w_n      = (r_order > ORDER_W'(MAX_ORDER)) ? (KW+1)'(MAX_ORDER)
                                                     : (KW+1)'(r_order);
    assign w_nn     = (AW+1)'(w_n * w_n);
    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    function automatic logic [AW:0] adv(input logic [AW:0] p, input logic [AW:0] nn);
        logic [AW:0] q;
        q = p + 1'b1;
        if (q >= nn || q >= (AW+1)'(DEPTH)) q = '0;
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_W'(MAX_ORDER);
        end else if (i_cfg_we) begin
            r_order <= i_cfg_data;
        end
    end

    // load path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apos <= '0;
            r_bpos <= '0;
            r_cpos <= '0;
        end else if (w_accept) begin
            unique case (i_action)
                ACT_LOAD_A: r_apos <= adv(r_apos, w_nn);
                ACT_LOAD_B: r_bpos <= adv(r_bpos, w_nn);
                ACT_LOAD_C: r_cpos <= adv(r_cpos, w_nn);
                ACT_RUN: begin
                    r_apos <= '0;
                    r_bpos <= '0;
                    r_cpos <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_action == ACT_LOAD_A && r_apos < (AW+1)'(DEPTH))
            r_a_mem[r_apos[AW-1:0]] <= i_operand_value;
        if (w_accept && i_action == ACT_LOAD_B && r_bpos < (AW+1)'(DEPTH))
            r_b_mem[r_bpos[AW-1:0]] <= i_operand_value;
        if (o_strobe_int)
            r_c_mem[w_wb_addr] <= w_cac[MAX_ORDER];
        else if (w_accept && i_action == ACT_LOAD_C && r_cpos < (AW+1)'(DEPTH))
            r_c_mem[r_cpos[AW-1:0]] <= i_accumulator_in;
    end

    // sequencer: ST_RUN fetches rows (k steps), ST_EMIT feeds one element
    assign w_rd_a = AW'(r_i * w_n + r_k);
    assign w_rd_b = AW'(r_j * w_n + r_k);
    assign w_rd_c = AW'(r_i * w_n + r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_feed <= 1'b0;
            r_emitted <= '0;
        end else begin
            r_feed <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_action == ACT_RUN && w_n != '0) begin
                        r_state <= ST_RUN;
                        r_i <= '0;
                        r_j <= '0;
                        r_k <= '0;
                        r_emitted <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_k == w_n - 1'b1) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_EMIT: begin
                    // hold until previous element drained to keep writeback order
                    if (o_strobe_int) begin
                        r_emitted <= r_emitted + 1'b1;
                        if (r_emitted + 1'b1 == w_nn) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= '0;
                            r_state <= ST_RUN;
                            if (r_j == w_n - 1'b1) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                    end else if (!r_inflight) begin
                        r_feed <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
        end else if (o_strobe_int) begin
            r_inflight <= 1'b0;
        end else if (r_state == ST_EMIT && !r_inflight) begin
            r_inflight <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) begin
            r_arow[r_k[KW-1:0]] <= r_a_mem[w_rd_a];
            r_brow[r_k[KW-1:0]] <= r_b_mem[w_rd_b];
            r_c0 <= r_c_mem[w_rd_c];
        end
    end

    // chain of cells; cell m adds a[m]*b[m] when m < n
    assign w_cv[0]  = r_feed;
    assign w_cac[0] = r_c0;
    assign w_cov[0] = 1'b0;

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < MAX_ORDER; m++) begin
            r_skew_a[0][m] <= r_arow[m];
            r_skew_b[0][m] <= r_brow[m];
            for (int s = 1; s < MAX_ORDER; s++) begin
                r_skew_a[s][m] <= r_skew_a[s-1][m];
                r_skew_b[s][m] <= r_skew_b[s-1][m];
            end
        end
    end

    for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
        logic signed [OPERAND_WIDTH-1:0] w_a, w_b;
        if (g == 0) begin : g_first
            assign w_a = r_arow[g];
            assign w_b = r_brow[g];
        end else begin : g_rest
            assign w_a = r_skew_a[g-1][g];
            assign w_b = r_skew_b[g-1][g];
        end
        mmta_cell #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .i_active((KW+1)'(g) < w_n),
            .i_a     (w_a),
            .i_b     (w_b),
            .i_acc   (w_cac[g]),
            .i_ovf   (w_cov[g]),
            .o_valid (w_cv[g+1]),
            .o_acc   (w_cac[g+1]),
            .o_ovf   (w_cov[g+1])
        );
    end

    assign o_strobe_int = w_cv[MAX_ORDER];
    assign w_wb_addr    = AW'(r_i * w_n + r_j);

    assign o_strobe       = o_strobe_int;
    assign o_result_value = w_cac[MAX_ORDER];
    assign o_result_row   = IDX_W'(r_i);
    assign o_result_col   = IDX_W'(r_j);
    assign o_overflow     = w_cov[MAX_ORDER];
    assign o_last         = (r_emitted + 1'b1 == w_nn);

    property p_no_strobe_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_strobe |-> busy;
    endproperty
    a_no_strobe_idle: assert property (p_no_strobe_idle) else $error("strobe while idle");

    property p_one_inflight;
        @(posedge i_clk) disable iff (!i_rst_n) r_feed |-> r_inflight;
    endproperty
    a_one_inflight: assert property (p_one_inflight) else $error("feed without inflight");

    property p_last_ends;
        @(posedge i_clk) disable iff (!i_rst_n) (o_strobe && o_last) |=> !busy;
    endproperty
    a_last_ends: assert property (p_last_ends) else $error("busy after last");
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the transposed matrix multiply-accumulate core against an in-bench
// model: phases of element loads and computes at several matrix orders, with
// random sender gaps, every emitted word compared field by field.
// ----------------------------------------------------------------------------
module tb;
    import mmta_pkg::*;

    localparam int DEPTH = 64;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = MAX_ORDER_DEF + 20;
    localparam longint SAT_HI = 64'sd549755813887;
    localparam longint SAT_LO = -64'sd549755813888;

    typedef struct {
        logic [1:0]              action;
        logic signed [15:0]      operand;
        logic signed [ACC_W-1:0] acc_in;
    } t_cmd;

    typedef struct {
        logic [ACC_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             ovf;
        logic             last;
    } t_elem;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_cfg_we;
    logic [ORDER_W-1:0]      i_cfg_data;
    logic [1:0]              i_action;
    logic signed [15:0]      i_operand_value;
    logic signed [ACC_W-1:0] i_accumulator_in;
    logic                    o_strobe;
    logic signed [ACC_W-1:0] o_result_value;
    logic [IDX_W-1:0]        o_result_row;
    logic [IDX_W-1:0]        o_result_col;
    logic                    o_overflow;
    logic                    o_last;

    t_cmd  cmd_q[$];
    t_elem c_expect_q[$];
    int    idle_pct;
    int    errors;
    int    quiet_cycles;

    // model of the engine, updated on accepted words
    logic [ORDER_W-1:0]      order_m;
    logic signed [15:0]      a_mem[DEPTH];
    logic signed [15:0]      b_mem[DEPTH];
    logic signed [ACC_W-1:0] c_mem[DEPTH];
    int                      a_pos, b_pos, c_pos;

    // stimulus-side tracking of positions and written slots
    int gen_order;
    int ga_pos, gb_pos, gc_pos;
    bit a_wr[DEPTH];
    bit b_wr[DEPTH];
    bit c_wr[DEPTH];

    matrix_multiply_transposed_accumulate_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_action(i_action),
        .i_operand_value(i_operand_value), .i_accumulator_in(i_accumulator_in),
        .o_strobe(o_strobe), .o_result_value(o_result_value),
        .o_result_row(o_result_row), .o_result_col(o_result_col),
        .o_overflow(o_overflow), .o_last(o_last)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int clamp_order(int v);
        return (v > MAX_ORDER_DEF) ? MAX_ORDER_DEF : v;
    endfunction

    function automatic int advance_pos(int p, int n);
        int q;
        q = p + 1;
        if (q >= n * n || q >= DEPTH) q = 0;
        return q;
    endfunction

    task automatic apply_word(t_cmd c);
        int     n;
        longint acc;
        bit     ovf;
        t_elem  e;
        n = clamp_order(order_m);
        case (c.action)
            ACT_LOAD_A: begin
                if (a_pos < DEPTH) a_mem[a_pos] = c.operand;
                a_pos = advance_pos(a_pos, n);
            end
            ACT_LOAD_B: begin
                if (b_pos < DEPTH) b_mem[b_pos] = c.operand;
                b_pos = advance_pos(b_pos, n);
            end
            ACT_LOAD_C: begin
                if (c_pos < DEPTH) c_mem[c_pos] = c.acc_in;
                c_pos = advance_pos(c_pos, n);
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = longint'(c_mem[i*n+j]);
                        ovf = 1'b0;
                        for (int k = 0; k < n; k++) begin
                            acc += longint'(a_mem[i*n+k]) * longint'(b_mem[j*n+k]);
                            if (acc > SAT_HI) begin acc = SAT_HI; ovf = 1'b1; end
                            if (acc < SAT_LO) begin acc = SAT_LO; ovf = 1'b1; end
                        end
                        c_mem[i*n+j] = acc[ACC_W-1:0];
                        e.value = acc[ACC_W-1:0];
                        e.row   = i[IDX_W-1:0];
                        e.col   = j[IDX_W-1:0];
                        e.ovf   = ovf;
                        e.last  = (i == n - 1) && (j == n - 1);
                        c_expect_q.push_back(e);
                    end
                end
                a_pos = 0;
                b_pos = 0;
                c_pos = 0;
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_word(cmd_q[0]);
                void'(cmd_q.pop_front());
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start            <= 1'b1;
                i_action         <= cmd_q[0].action;
                i_operand_value  <= cmd_q[0].operand;
                i_accumulator_in <= cmd_q[0].acc_in;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_elem e;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (c_expect_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word row %0d col %0d",
                                               o_result_row, o_result_col);
                end else begin
                    e = c_expect_q.pop_front();
                    if (o_result_value !== e.value || o_result_row !== e.row ||
                        o_result_col !== e.col || o_overflow !== e.ovf ||
                        o_last !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %h r%0d c%0d o%0b l%0b got %h r%0d c%0d o%0b l%0b",
                                     e.value, e.row, e.col, e.ovf, e.last,
                                     o_result_value, o_result_row, o_result_col,
                                     o_overflow, o_last);
                    end
                end
            end
            if (o_strobe || (start && !busy)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] rand_operand();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [ACC_W-1:0] rand_acc();
        logic [ACC_W-1:0] r;
        r = ACC_W'({$urandom, $urandom});
        case ($urandom_range(7))
            0: return ACC_MAX - ACC_W'($urandom_range(1 << 20));
            1: return ACC_MIN + ACC_W'($urandom_range(1 << 20));
            2: return {{20{r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    task automatic push_load(logic [1:0] act, logic signed [15:0] op,
                             logic signed [ACC_W-1:0] acc);
        t_cmd c;
        int   n;
        c.action  = act;
        c.operand = op;
        c.acc_in  = acc;
        n = clamp_order(gen_order);
        case (act)
            ACT_LOAD_A: begin a_wr[ga_pos] = 1; ga_pos = advance_pos(ga_pos, n); end
            ACT_LOAD_B: begin b_wr[gb_pos] = 1; gb_pos = advance_pos(gb_pos, n); end
            default:    begin c_wr[gc_pos] = 1; gc_pos = advance_pos(gc_pos, n); end
        endcase
        cmd_q.push_back(c);
    endtask

    task automatic push_random_load(logic [1:0] act);
        push_load(act, rand_operand(), rand_acc());
    endtask

    function automatic logic [1:0] missing_store();
        int n;
        n = clamp_order(gen_order);
        for (int s = 0; s < n * n; s++) begin
            if (!a_wr[s]) return ACT_LOAD_A;
            if (!b_wr[s]) return ACT_LOAD_B;
            if (!c_wr[s]) return ACT_LOAD_C;
        end
        return ACT_RUN;
    endfunction

    task automatic push_compute();
        t_cmd        c;
        logic [1:0]  m;
        m = missing_store();
        while (m != ACT_RUN) begin
            push_random_load(m);
            m = missing_store();
        end
        c.action  = ACT_RUN;
        c.operand = 16'($urandom);
        c.acc_in  = rand_acc();
        cmd_q.push_back(c);
        ga_pos = 0;
        gb_pos = 0;
        gc_pos = 0;
    endtask

    // full A/B load and, unless C is kept, a C load in random interleave, then a compute
    task automatic push_sequence();
        int         nn;
        int         left[3];
        int         pick;
        bit         keep_c;
        nn = clamp_order(gen_order) ** 2;
        keep_c = (missing_store() == ACT_RUN) && ($urandom_range(2) == 0);
        left[0] = nn;
        left[1] = nn;
        left[2] = keep_c ? 0 : nn;
        while (left[0] + left[1] + left[2] > 0) begin
            pick = $urandom_range(2);
            if (left[pick] > 0) begin
                push_random_load(pick[1:0]);
                left[pick]--;
            end
            if ($urandom_range(40) == 0) push_random_load(2'($urandom_range(2)));
        end
        push_compute();
    endtask

    task automatic drain_and_set_order(int v);
        while (cmd_q.size() != 0 || c_expect_q.size() != 0 || start) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[ORDER_W-1:0];
        order_m    = v[ORDER_W-1:0];
        gen_order  = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int orders[5] = '{1, 15, 0, 3, 2};
        int gaps[4]   = '{0, 51, 0, 18};
        int budget;
        start = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        i_action = ACT_LOAD_A;
        i_operand_value = 0;
        i_accumulator_in = 0;
        idle_pct = 0;
        errors = 0;
        quiet_cycles = 0;
        order_m = 4'd8;
        gen_order = 8;
        a_pos = 0; b_pos = 0; c_pos = 0;
        ga_pos = 0; gb_pos = 0; gc_pos = 0;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: order 2, operand extremes driving both saturation limits
        drain_and_set_order(2);
        push_load(ACT_LOAD_A, 16'sh7fff, 0);
        push_load(ACT_LOAD_A, 16'sh8000, 0);
        push_load(ACT_LOAD_A, 16'sh8000, 0);
        push_load(ACT_LOAD_A, 16'sh7fff, 0);
        push_load(ACT_LOAD_B, 16'sh7fff, 0);
        push_load(ACT_LOAD_B, 16'sh8000, 0);
        push_load(ACT_LOAD_B, 16'sh0000, 0);
        push_load(ACT_LOAD_B, 16'shffff, 0);
        push_load(ACT_LOAD_C, 0, ACC_MAX);
        push_load(ACT_LOAD_C, 0, ACC_MIN);
        push_load(ACT_LOAD_C, 0, ACC_MIN);
        push_load(ACT_LOAD_C, 0, -40'sd1);
        push_compute();
        push_compute();
        push_load(ACT_LOAD_C, 0, 40'sh0000_0000_01);
        push_load(ACT_LOAD_A, 16'sh0100, 0);

        for (int ph = 0; ph < 5; ph++) begin
            drain_and_set_order(orders[ph]);
            idle_pct = gaps[ph % 4];
            budget = 4;
            while (budget > 0) begin
                push_sequence();
                budget -= clamp_order(gen_order) ** 2 * 3 + 1;
                if ($urandom_range(1) == 0) push_compute();
            end
            repeat ($urandom_range(3)) push_random_load(2'($urandom_range(2)));
            if (orders[ph] == 0) begin
                push_compute();
                push_random_load(ACT_LOAD_A);
            end
        end

        while (cmd_q.size() != 0 || c_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
